>>> hw/rtl/tcst_pkg.sv
// shared types, codes and constants of the touch contact slot tracker
package tcst_pkg;

	localparam int unsigned SLOTS_DEFAULT = 16;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned ID_W          = 16;
	localparam int unsigned POS_W         = 16;
	localparam int unsigned MASK_W        = 16;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_DOWN  = 2'd1,
		CMD_UP    = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_UP        = 2'd0,
		PH_JUST_DOWN = 2'd1,
		PH_DOWN      = 2'd2,
		PH_JUST_UP   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_QUERY,
		ST_EMIT
	} state_t;

	// one slot's stored contact
	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} entry_t;

	// strobes towards the entry store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

endpackage

>>> hw/rtl/tcst_if.sv
// request and result channel interfaces of the touch contact slot tracker
interface tcst_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        command;
	logic [tcst_pkg::ID_W-1:0]         contact_id;
	logic signed [tcst_pkg::POS_W-1:0] pos_x;
	logic signed [tcst_pkg::POS_W-1:0] pos_y;
	logic [tcst_pkg::IDX_W-1:0]        query_slot;

	modport source (output valid, command, contact_id, pos_x, pos_y, query_slot, input ready);
	modport sink (input valid, command, contact_id, pos_x, pos_y, query_slot, output ready);
endinterface

interface tcst_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tcst_pkg::IDX_W-1:0]        slot_index;
	logic                              hit;
	logic [1:0]                        slot_phase;
	logic signed [tcst_pkg::POS_W-1:0] slot_x;
	logic signed [tcst_pkg::POS_W-1:0] slot_y;
	logic [tcst_pkg::MASK_W-1:0]       active_mask;

	modport source (output valid, slot_index, hit, slot_phase, slot_x, slot_y, active_mask,
		input ready);
	modport sink (input valid, slot_index, hit, slot_phase, slot_x, slot_y, active_mask,
		output ready);
endinterface

>>> hw/rtl/touch_contact_slot_tracker_core.sv
// top level of the touch contact slot tracker: sequencer, slot state and result register
//
// Tracks up to SLOTS touch contacts in a slot table. A down request takes the lowest free
// slot, an up request frees the lowest slot holding the id, a tick ages just-down slots to
// down and just-up slots to up, and a query reads one slot. Every result carries a mask of
// the slots (0 to 15) in phase down. One request is in work at a time; req.ready is high
// only while the sequencer is idle. A tick goes from idle straight to the emit state and a
// query passes through the query state first. Down and up requests walk the table one slot
// per cycle through one shared compare unit fed by the registered read of the entry store,
// and a scan ends on the first matching slot or after the last slot. The result
// sits in an output register, so a new request is taken while the previous result waits;
// a finished request only stalls in its final cycle when that register is still full.
// Contact ids and positions live in a memory with no reset; a per-slot written bit makes
// a never-written slot read back a zero position.
module touch_contact_slot_tracker_core #(
	parameter int unsigned SLOTS = tcst_pkg::SLOTS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	tcst_req_if.sink   req,
	tcst_rsp_if.source rsp
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	// sequencer
	tcst_pkg::state_t state_q, state_d;
	logic             req_fire;

	// request held for the duration of the work
	tcst_pkg::cmd_t                    cmd_q;
	logic [tcst_pkg::ID_W-1:0]         id_q;
	logic signed [tcst_pkg::POS_W-1:0] x_q;
	logic signed [tcst_pkg::POS_W-1:0] y_q;
	logic [tcst_pkg::IDX_W-1:0]        qs_q;

	// scan address counter and the compare stage behind the store read
	logic [AW-1:0] cnt_q;
	logic          valid_s1;
	logic [AW-1:0] idx_s1;

	// per-slot state in flops
	logic [SLOTS-1:0]  owner_valid_q;
	logic [SLOTS-1:0]  written_q;
	tcst_pkg::phase_t  phase_q [SLOTS];

	// result being assembled
	logic [tcst_pkg::IDX_W-1:0]        res_idx_q;
	logic                              res_hit_q;
	tcst_pkg::phase_t                  res_phase_q;
	logic signed [tcst_pkg::POS_W-1:0] res_x_q;
	logic signed [tcst_pkg::POS_W-1:0] res_y_q;

	// output register
	logic                              rsp_valid_q;
	logic [tcst_pkg::IDX_W-1:0]        rsp_idx_q;
	logic                              rsp_hit_q;
	tcst_pkg::phase_t                  rsp_phase_q;
	logic signed [tcst_pkg::POS_W-1:0] rsp_x_q;
	logic signed [tcst_pkg::POS_W-1:0] rsp_y_q;
	logic [tcst_pkg::MASK_W-1:0]       rsp_mask_q;
	logic                              load_out;

	// entry store
	tcst_pkg::ram_ctl_t ram_ctl;
	logic [AW-1:0]      rd_addr;
	tcst_pkg::entry_t   wr_data;
	tcst_pkg::entry_t   rd_data;

	// shared compare unit
	logic cmp_match;
	logic scan_hit;
	logic scan_last;

	// query decode
	logic [AW-1:0] qa;
	logic          q_in_range;

	logic [tcst_pkg::MASK_W-1:0] down_mask;

	assign req_fire = req.valid && req.ready;

	// down looks for a free slot, up for an occupied slot holding the id
	always_comb begin
		if (cmd_q == tcst_pkg::CMD_DOWN) begin
			cmp_match = !owner_valid_q[idx_s1];
		end else begin
			cmp_match = owner_valid_q[idx_s1] && (rd_data.id == id_q);
		end
	end

	assign scan_hit  = valid_s1 && cmp_match;
	assign scan_last = valid_s1 && (idx_s1 == LAST);

	assign qa         = AW'(qs_q);
	assign q_in_range = (32'(qs_q) < SLOTS);

	// store access: query address straight from the request, scan address otherwise
	assign rd_addr       = (state_q == tcst_pkg::ST_IDLE) ? AW'(req.query_slot) : cnt_q;
	assign ram_ctl.rd_en = (state_q == tcst_pkg::ST_IDLE) || (state_q == tcst_pkg::ST_SCAN);
	assign ram_ctl.wr_en = (state_q == tcst_pkg::ST_SCAN) && scan_hit &&
		(cmd_q == tcst_pkg::CMD_DOWN);
	assign wr_data.id    = id_q;
	assign wr_data.x     = x_q;
	assign wr_data.y     = y_q;

	tcst_entry_ram #(
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_entry_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_addr (idx_s1),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// mask of down slots, only the first sixteen are visible
	for (genvar g = 0; g < tcst_pkg::MASK_W; g++) begin : g_mask
		if (g < SLOTS) begin : g_slot
			assign down_mask[g] = (phase_q[g] == tcst_pkg::PH_DOWN);
		end else begin : g_none
			assign down_mask[g] = 1'b0;
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			tcst_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (tcst_pkg::cmd_t'(req.command))
						tcst_pkg::CMD_TICK:                   state_d = tcst_pkg::ST_EMIT;
						tcst_pkg::CMD_DOWN, tcst_pkg::CMD_UP: state_d = tcst_pkg::ST_SCAN;
						tcst_pkg::CMD_QUERY:                  state_d = tcst_pkg::ST_QUERY;
						default:                              state_d = tcst_pkg::ST_IDLE;
					endcase
				end
			end
			tcst_pkg::ST_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = tcst_pkg::ST_EMIT;
				end
			end
			tcst_pkg::ST_QUERY: begin
				state_d = tcst_pkg::ST_EMIT;
			end
			tcst_pkg::ST_EMIT: begin
				// wait only while the previous result is still unclaimed
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = tcst_pkg::ST_IDLE;
				end
			end
			default: state_d = tcst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= tcst_pkg::cmd_t'(req.command);
			id_q  <= req.contact_id;
			x_q   <= req.pos_x;
			y_q   <= req.pos_y;
			qs_q  <= req.query_slot;
		end
	end

	// scan counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (req_fire) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (state_q == tcst_pkg::ST_SCAN) begin
			valid_s1 <= (state_d == tcst_pkg::ST_SCAN);
			idx_s1   <= cnt_q;
			if (cnt_q != LAST) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end else begin
			valid_s1 <= 1'b0;
		end
	end

	// slot ownership and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_valid_q <= '0;
			written_q     <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				phase_q[i] <= tcst_pkg::PH_UP;
			end
		end else if (req_fire && (tcst_pkg::cmd_t'(req.command) == tcst_pkg::CMD_TICK)) begin
			// frame tick ages every slot at once
			for (int i = 0; i < SLOTS; i++) begin
				if (phase_q[i] == tcst_pkg::PH_JUST_UP) begin
					phase_q[i] <= tcst_pkg::PH_UP;
				end else if (phase_q[i] == tcst_pkg::PH_JUST_DOWN) begin
					phase_q[i] <= tcst_pkg::PH_DOWN;
				end
			end
		end else if ((state_q == tcst_pkg::ST_SCAN) && scan_hit) begin
			if (cmd_q == tcst_pkg::CMD_DOWN) begin
				owner_valid_q[idx_s1] <= 1'b1;
				written_q[idx_s1]     <= 1'b1;
				phase_q[idx_s1]       <= tcst_pkg::PH_JUST_DOWN;
			end else begin
				// position stays as it was
				owner_valid_q[idx_s1] <= 1'b0;
				phase_q[idx_s1]       <= tcst_pkg::PH_JUST_UP;
			end
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_idx_q   <= '0;
			res_hit_q   <= 1'b0;
			res_phase_q <= tcst_pkg::PH_UP;
			res_x_q     <= '0;
			res_y_q     <= '0;
		end else if ((state_q == tcst_pkg::ST_SCAN) && scan_hit) begin
			res_idx_q <= tcst_pkg::IDX_W'(idx_s1);
			res_hit_q <= 1'b1;
		end else if (state_q == tcst_pkg::ST_QUERY) begin
			res_idx_q <= qs_q;
			if (q_in_range) begin
				res_hit_q   <= 1'b1;
				res_phase_q <= phase_q[qa];
				// a slot never written reads back a zero position
				res_x_q     <= written_q[qa] ? rd_data.x : '0;
				res_y_q     <= written_q[qa] ? rd_data.y : '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_idx_q   <= res_idx_q;
			rsp_hit_q   <= res_hit_q;
			rsp_phase_q <= res_phase_q;
			rsp_x_q     <= res_x_q;
			rsp_y_q     <= res_y_q;
			rsp_mask_q  <= down_mask;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.slot_index  = rsp_idx_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.slot_phase  = rsp_phase_q;
	assign rsp.slot_x      = rsp_x_q;
	assign rsp.slot_y      = rsp_y_q;
	assign rsp.active_mask = rsp_mask_q;

	// an occupied slot is always just-down or down, a free one up or just-up
	for (genvar g = 0; g < SLOTS; g++) begin : g_chk
		a_owner_phase: assert property (@(posedge clk) disable iff (!arst_n)
			owner_valid_q[g] |-> (phase_q[g] == tcst_pkg::PH_JUST_DOWN) ||
				(phase_q[g] == tcst_pkg::PH_DOWN))
			else $error("occupied slot in a free phase");
		a_free_phase: assert property (@(posedge clk) disable iff (!arst_n)
			!owner_valid_q[g] |-> (phase_q[g] == tcst_pkg::PH_UP) ||
				(phase_q[g] == tcst_pkg::PH_JUST_UP))
			else $error("free slot in an occupied phase");
	end

	a_down_takes: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tcst_pkg::ST_SCAN) && scan_hit && (cmd_q == tcst_pkg::CMD_DOWN))
		|=> owner_valid_q[$past(idx_s1)])
		else $error("down hit did not occupy its slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!rsp_valid_q || rsp.ready))
		else $error("result register overwritten while held");

	a_stage_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == tcst_pkg::ST_SCAN))
		else $error("compare stage live outside a scan");

endmodule

>>> hw/rtl/tcst_entry_ram.sv
// single-port-write, registered-read store of contact id and position per slot
module tcst_entry_ram #(
	parameter int unsigned DEPTH = tcst_pkg::SLOTS_DEFAULT,
	parameter int unsigned AW    = 4
) (
	input  logic               clk,
	input  tcst_pkg::ram_ctl_t ctl,
	input  logic [AW-1:0]      wr_addr,
	input  tcst_pkg::entry_t   wr_data,
	input  logic [AW-1:0]      rd_addr,
	output tcst_pkg::entry_t   rd_data
);

	tcst_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
